// File: design/xtea_block_cipher_top_assert.svh
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared macros for the concurrent checks of the cipher engine.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_TOP_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define XTEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define XTEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Types, constants and the round mixing function shared by the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned KEY_IDX_W  = 2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  // Payload of one block as it travels down the round chain.
  typedef struct packed {
    logic        op;
    logic [31:0] left;
    logic [31:0] right;
  } blk_t;

  function automatic logic [31:0] mix(input logic [31:0] x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

// File: design/xtea_if.sv
// ----------------------------------------------------------------------------
// XTEA stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] block_left;
  logic [31:0] block_right;

  modport source (output valid, output op, output block_left, output block_right,
                  input ready);
  modport sink   (input valid, input op, input block_left, input block_right,
                  output ready);
endinterface

interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_left;
  logic [31:0] result_right;

  modport source (output valid, output result_left, output result_right,
                  input ready);
  modport sink   (input valid, input result_left, input result_right,
                  output ready);
endinterface

// File: design/xtea_cell.sv
// ----------------------------------------------------------------------------
// XTEA round cell
// One full XTEA cycle as two registered half-rounds, for either direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_cell #(
  parameter int ROUND  = 0,
  parameter int CYCLES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  xtea_pkg::key_t key,
  input  logic          in_valid,
  input  xtea_pkg::blk_t in_blk,
  output logic          out_valid,
  output xtea_pkg::blk_t out_blk
);
  import xtea_pkg::*;

  // Running sums for this cycle, fixed by its position in the chain.
  localparam logic [63:0] ENC_P0 = 64'(XTEA_DELTA) * 64'(ROUND);
  localparam logic [63:0] ENC_P1 = 64'(XTEA_DELTA) * 64'(ROUND + 1);
  localparam logic [63:0] DEC_PA = 64'(XTEA_DELTA) * 64'(CYCLES - ROUND);
  localparam logic [63:0] DEC_PB = 64'(XTEA_DELTA) * 64'(CYCLES - ROUND - 1);
  localparam logic [31:0] ENC_S0 = ENC_P0[31:0];
  localparam logic [31:0] ENC_S1 = ENC_P1[31:0];
  localparam logic [31:0] DEC_SA = DEC_PA[31:0];
  localparam logic [31:0] DEC_SB = DEC_PB[31:0];
  localparam logic [KEY_IDX_W-1:0] ENC_K0 = ENC_S0[1:0];
  localparam logic [KEY_IDX_W-1:0] ENC_K1 = ENC_S1[12:11];
  localparam logic [KEY_IDX_W-1:0] DEC_KA = DEC_SA[12:11];
  localparam logic [KEY_IDX_W-1:0] DEC_KB = DEC_SB[1:0];

  logic        mid_valid;
  blk_t        mid_blk;
  blk_t        mid_next;
  blk_t        out_next;
  logic [31:0] sub1;
  logic [31:0] f1;
  logic [31:0] sub2;
  logic [31:0] f2;

  // First half: encrypt updates the left word, decrypt undoes the right word.
  always_comb begin
    mid_next = in_blk;
    if (in_blk.op == OP_DECRYPT) begin
      sub1 = DEC_SA + key[DEC_KA];
      f1   = mix(in_blk.left) ^ sub1;
      mid_next.right = in_blk.right - f1;
    end else begin
      sub1 = ENC_S0 + key[ENC_K0];
      f1   = mix(in_blk.right) ^ sub1;
      mid_next.left = in_blk.left + f1;
    end
  end

  // Second half: the other word, with the sum one step further on.
  always_comb begin
    out_next = mid_blk;
    if (mid_blk.op == OP_DECRYPT) begin
      sub2 = DEC_SB + key[DEC_KB];
      f2   = mix(mid_blk.right) ^ sub2;
      out_next.left = mid_blk.left - f2;
    end else begin
      sub2 = ENC_S1 + key[ENC_K1];
      f2   = mix(mid_blk.left) ^ sub2;
      out_next.right = mid_blk.right + f2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_blk <= mid_next;
      out_blk <= out_next;
    end
  end

endmodule

// File: design/xtea_out_stage.sv
// ----------------------------------------------------------------------------
// XTEA output stage
// Output register with a one-entry skid buffer that stalls the round chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xtea_block_cipher_top_assert.svh"

module xtea_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              last_valid,
  input  xtea_pkg::blk_t    last_blk,
  output logic              en,
  xtea_out_if.source        results
);
  import xtea_pkg::*;

  logic        out_valid;
  logic [31:0] out_left;
  logic [31:0] out_right;
  logic        skid_valid;
  logic [31:0] skid_left;
  logic [31:0] skid_right;
  logic        take;

  assign take                 = out_valid && results.ready;
  assign en                   = !skid_valid;
  assign results.valid        = out_valid;
  assign results.result_left  = out_left;
  assign results.result_right = out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_left   <= skid_left;
        out_right  <= skid_right;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= last_valid;
      out_left  <= last_blk.left;
      out_right <= last_blk.right;
    end else if (last_valid) begin
      skid_valid <= 1'b1;
      skid_left  <= last_blk.left;
      skid_right <= last_blk.right;
    end
  end

  `XTEA_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `XTEA_ASSERT_NOW(a_skid_cause, $rose(skid_valid), $past(out_valid && !results.ready), "skid filled without a stall")
  `XTEA_ASSERT_NEXT(a_skid_drain, skid_valid && take, out_valid && !skid_valid, "skid item not moved to output")
  `XTEA_ASSERT_NEXT(a_empty_fill, !skid_valid && !out_valid && last_valid, out_valid, "finished item dropped")

endmodule

// File: design/xtea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// XTEA block cipher engine
// Fully pipelined XTEA encrypt/decrypt over a 64-bit block and 128-bit key.
// ----------------------------------------------------------------------------
// The engine accepts one 64-bit block per clock cycle on the blocks channel
// while the chain advances, and returns one result block per item on the
// results channel, in the order the items were accepted. Each item's op bit
// selects encryption or decryption, so both directions may be mixed freely
// in the stream. The datapath is a chain of CYCLES identical round cells;
// each cell performs one XTEA cycle as two registered half-rounds, and the
// first half-round register loads at the edge that accepts the item. The
// output register sits behind the chain, and the sustained rate is one item
// per cycle while the results channel keeps taking them. The running delta
// sum of each cell is fixed by its position in the chain, so only the key
// words travel to the cells. The key is written through the plain write
// port (index 0 to 3 for key words 0 to 3) and must only be changed while
// no item is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_block_cipher_top #(
  parameter int CYCLES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [xtea_pkg::KEY_IDX_W-1:0]    wr_index,
  input  logic [31:0]                       wr_data,
  xtea_in_if.sink                           blocks,
  xtea_out_if.source                        results
);
  import xtea_pkg::*;

  // Key registers; they reset to the all-zero key.
  key_t key;

  // Chain taps: tap 0 is the input channel, tap CYCLES the last cell's output.
  logic stage_valid [0:CYCLES];
  blk_t stage_blk   [0:CYCLES];

  // Whole-chain advance; it drops only while the skid buffer holds an item.
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      key[wr_index] <= wr_data;
    end
  end

  // The chain moves as one, so an item is accepted whenever it advances.
  assign blocks.ready        = en;
  assign stage_valid[0]      = blocks.valid;
  assign stage_blk[0].op     = blocks.op;
  assign stage_blk[0].left   = blocks.block_left;
  assign stage_blk[0].right  = blocks.block_right;

  // One cell per XTEA cycle. Encryption walks the cells with the sum rising,
  // decryption walks the same cells with the sum falling from its final value.
  for (genvar r = 0; r < CYCLES; r++) begin : g_round
    xtea_cell #(
      .ROUND  (r),
      .CYCLES (CYCLES)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .key       (key),
      .in_valid  (stage_valid[r]),
      .in_blk    (stage_blk[r]),
      .out_valid (stage_valid[r+1]),
      .out_blk   (stage_blk[r+1])
    );
  end

  // The output register and skid buffer keep the input side taking items
  // while a finished result waits, and cut the ready path from the chain.
  xtea_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .last_valid (stage_valid[CYCLES]),
    .last_blk   (stage_blk[CYCLES]),
    .en         (en),
    .results    (results)
  );

endmodule

// File: tb/xtea_block_cipher_top_tb.sv
// ----------------------------------------------------------------------------
// XTEA block cipher engine testbench
// Streams encrypt and decrypt blocks through the engine under several keys,
// predicts every result block from the key and the accepted input item, and
// checks the results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_block_cipher_top_tb;

  import xtea_pkg::*;

  // Number of Feistel cycles in the engine. The engine default is used.
  localparam int ROUNDS = 32;

  // Pipeline depth from acceptance to the results channel, plus some margin.
  localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;

  // The run is abandoned after this many clock cycles.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int MAX_PRINTED = 40;

  // One 64-bit block with the op bit that goes with it.
  typedef struct packed {
    logic        op;
    logic [31:0] left;
    logic [31:0] right;
  } block_item_t;

  // One result block as it leaves the engine.
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } result_block_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the key, computes the cipher result of
  // every accepted item and compares the result blocks in arrival order.
  // --------------------------------------------------------------------------
  class xtea_scoreboard;
    logic [31:0]   key_words [4];
    result_block_t expected_blocks [$];
    int            errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        key_words[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_key_word(int idx, logic [31:0] value);
      key_words[idx] = value;
    endfunction

    // Shift-and-add spreading term of one half-round.
    function logic [31:0] spread(logic [31:0] x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Full XTEA pass over one block under the current key.
    function result_block_t cipher(block_item_t blk);
      logic [31:0]   left;
      logic [31:0]   right;
      logic [31:0]   total;
      result_block_t res;
      left  = blk.left;
      right = blk.right;
      if (blk.op == OP_ENCRYPT) begin
        total = '0;
        for (int n = 0; n < ROUNDS; n++) begin
          left  = left + (spread(right) ^ (total + key_words[total[1:0]]));
          total = total + XTEA_DELTA;
          right = right + (spread(left) ^ (total + key_words[total[12:11]]));
        end
      end else begin
        total = XTEA_DELTA * ROUNDS;
        for (int n = 0; n < ROUNDS; n++) begin
          right = right - (spread(left) ^ (total + key_words[total[12:11]]));
          total = total - XTEA_DELTA;
          left  = left - (spread(right) ^ (total + key_words[total[1:0]]));
        end
      end
      res.left  = left;
      res.right = right;
      return res;
    endfunction

    function void note_block(block_item_t blk);
      expected_blocks.push_back(cipher(blk));
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    task check_result(result_block_t got);
      result_block_t want;
      if (expected_blocks.size() == 0) begin
        report($sformatf("result block %h_%h with none outstanding",
                         got.left, got.right));
      end else begin
        want = expected_blocks.pop_front();
        if (got.left !== want.left) begin
          report($sformatf("result_left %h, expected %h", got.left, want.left));
        end
        if (got.right !== want.right) begin
          report($sformatf("result_right %h, expected %h", got.right, want.right));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the engine under test.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [KEY_IDX_W-1:0] wr_index;
  logic [31:0] wr_data;

  xtea_in_if  blk_ch ();
  xtea_out_if res_ch ();

  xtea_block_cipher_top #(
    .CYCLES(ROUNDS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .blocks  (blk_ch),
    .results (res_ch)
  );

  xtea_scoreboard sb;

  // When set, neither side idles, so the engine is driven at its full rate
  // of one item per cycle with no stalls on the results channel.
  bit   full_rate;
  int   cycle_count;

  // Recent items, whose results are used to feed ciphertext back in for
  // decryption (and plaintext for encryption) under the same key.
  block_item_t recent_items [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every input of the engine holds a known value from time zero onwards.
  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    blk_ch.valid       = 1'b0;
    blk_ch.op          = OP_ENCRYPT;
    blk_ch.block_left  = '0;
    blk_ch.block_right = '0;
    res_ch.ready       = 1'b0;
  end

  // Gap length for either side: mostly none or a few cycles, now and then a
  // long pause so that stalls land deep inside the pipeline as well.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (full_rate) begin
      return 0;
    end
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Results side: ready is held low for random stretches. A new stall length
  // is drawn on roughly a third of the cycles on which ready is high; it may be zero.
  // --------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  initial stall_left = 0;

  // --------------------------------------------------------------------------
  // Monitors. Both sample at the rising edge, before any of this edge's
  // nonblocking updates, so they see exactly what the engine sees.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    block_item_t   accepted;
    result_block_t arrived;
    if (!rst) begin
      if (blk_ch.valid && blk_ch.ready) begin
        accepted.op    = blk_ch.op;
        accepted.left  = blk_ch.block_left;
        accepted.right = blk_ch.block_right;
        sb.note_block(accepted);
      end
      if (res_ch.valid && res_ch.ready) begin
        arrived.left  = res_ch.result_left;
        arrived.right = res_ch.result_right;
        sb.check_result(arrived);
      end
    end
  end

  // A hung engine must not stall the run for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial cycle_count = 0;

  // --------------------------------------------------------------------------
  // Driver tasks.
  // --------------------------------------------------------------------------

  // Offers one item and returns at the edge where it was accepted. Valid is
  // left high so that a back-to-back item follows without a bubble; it only
  // drops when a gap is chosen or the phase ends.
  task automatic send_block(block_item_t blk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      blk_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk_ch.valid       <= 1'b1;
    blk_ch.op          <= blk.op;
    blk_ch.block_left  <= blk.left;
    blk_ch.block_right <= blk.right;
    do begin
      @(posedge clk);
    end while (!blk_ch.ready);
    recent_items.push_back(blk);
    if (recent_items.size() > 16) begin
      void'(recent_items.pop_front());
    end
  endtask

  // Lowers valid and waits until every expected result block has come out.
  // Every item yields a result, so an empty store means an empty pipeline;
  // a few extra cycles are allowed all the same.
  task automatic drain();
    blk_ch.valid <= 1'b0;
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes all four key words on consecutive cycles. Only called while the
  // engine is empty.
  task automatic load_key(logic [31:0] k0, logic [31:0] k1,
                          logic [31:0] k2, logic [31:0] k3);
    logic [31:0] words [4];
    words = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= KEY_IDX_W'(i);
      wr_data  <= words[i];
      @(posedge clk);
      sb.set_key_word(i, words[i]);
    end
    wr_en <= 1'b0;
    recent_items.delete();
  endtask

  // Short fixed list: the extremes of both halves in both directions, single
  // bits at either end of each half, and one ordinary block.
  task automatic run_directed();
    block_item_t blk;
    logic [31:0] corner [5];
    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
               32'h0123_4567};
    for (int i = 0; i < 5; i++) begin
      blk.left  = corner[i];
      blk.right = corner[4 - i];
      blk.op    = OP_ENCRYPT;
      send_block(blk);
      blk.op    = OP_DECRYPT;
      send_block(blk);
    end
  endtask

  // Random part of one phase. Most items are fresh random blocks; some send
  // a recent result back the other way, which must give the original block
  // again; the rest are patterned: sparse or dense bits, or two equal halves.
  task automatic run_random(int count);
    block_item_t   blk;
    block_item_t   earlier;
    result_block_t prior_result;
    int            kind;
    int            bit_pos;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind >= 6 && kind <= 7 && recent_items.size() > 0) begin
        earlier      = recent_items[$urandom_range(0, recent_items.size() - 1)];
        prior_result = sb.cipher(earlier);
        blk.op       = (earlier.op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
        blk.left     = prior_result.left;
        blk.right    = prior_result.right;
      end else if (kind >= 8) begin
        bit_pos   = $urandom_range(0, 31);
        blk.op    = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
        case ($urandom_range(0, 3))
          0: begin
            blk.left  = 32'h1 << bit_pos;
            blk.right = '0;
          end
          1: begin
            blk.left  = '1;
            blk.right = ~(32'h1 << bit_pos);
          end
          2: begin
            blk.left  = $urandom;
            blk.right = blk.left;
          end
          default: begin
            blk.left  = ~(32'h1 << bit_pos);
            blk.right = 32'h1 << bit_pos;
          end
        endcase
      end else begin
        blk.op    = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
        blk.left  = $urandom;
        blk.right = $urandom;
      end
      send_block(blk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    full_rate = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The key has never been written here, so the all-zero reset key must
    // be in use.
    run_directed();
    drain();

    // All-ones key: the other extreme of every key bit.
    load_key('1, '1, '1, '1);
    run_directed();
    run_random(180);
    drain();

    // Random key at full rate: back-to-back items and no result stalls.
    full_rate = 1'b1;
    load_key($urandom, $urandom, $urandom, $urandom);
    run_random(180);
    drain();
    full_rate = 1'b0;

    // Alternating bit patterns, distinct in every word, so that a wrong key
    // word selection shows up.
    load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    run_random(180);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    run_random(180);
    drain();

    // Back to the zero key, this time written explicitly.
    load_key('0, '0, '0, '0);
    run_random(180);
    drain();

    // Only key word 2 set, so that its use is seen on its own.
    load_key('0, '0, $urandom, '0);
    run_random(100);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    run_random(90);
    drain();

    // Anything that turns up now has no item behind it and is a failure.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.report($sformatf("%0d result blocks never arrived", sb.pending()));
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
